[design/ipv4_pkg.sv]
// Shared types and constants of the IPv4 dotted-quad parser.
package ipv4_pkg;

	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [2:0] MAX_DIGITS = 3'd3;
	localparam logic [2:0] SAT_COUNT  = 3'd4;
	localparam logic [2:0] DOTS_OK    = 3'd3;
	localparam logic [9:0] MAX_OCTET  = 10'd255;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_PARTS   = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_LONG    = 3'd3,
		ST_BADCHAR = 3'd4,
		ST_RANGE   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_DOT   = 2'd1,
		KIND_DIGIT = 2'd2,
		KIND_OTHER = 2'd3
	} char_kind_t;

	typedef struct packed {
		char_kind_t  kind;
		logic [3:0]  digit;
		logic        last;
	} char_req_t;

endpackage

[design/ipv4_dotted_quad_parser.sv]
// Top level of the IPv4 dotted-quad parser.
// The input channel (in_valid, in_stall) takes one character request per cycle
// while in_stall is low: character, has_character and last. A request with last
// set closes the string and produces exactly one result request on the output
// channel (out_valid, out_stall): the packed address, first octet in bits 31..24,
// and a status. The address is zero whenever the status is not ok.
// A character accepted at one clock edge is classified and written into a
// four-entry queue; the back end consumes one request per cycle, though a
// request ending a string waits while a stalled result is held, so the
// sustained rate is one character per cycle. A string's result is written to the
// result register as its last character leaves the queue and held there while
// out_stall is high. The back end keeps draining characters that do not end a
// string; the queue fills only when a finished result waits, and in_stall rises
// when the queue is full. Reset clears the queue, the parse state and the result
// valid flag (not address and status): a fresh string starts with no result pending.
module ipv4_dotted_quad_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        has_character,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] address,
	output logic [2:0]  status
);

	ipv4_pkg::char_req_t push_data;
	ipv4_pkg::char_req_t pop_data;
	logic                push;
	logic                pop;
	logic                full;
	logic                not_empty;

	ipv4_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.character     (character),
		.has_character (has_character),
		.last          (last),
		.q_full        (full),
		.q_push        (push),
		.q_data        (push_data)
	);

	ipv4_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	ipv4_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_data      (pop_data),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.address     (address),
		.status      (status)
	);

endmodule

[design/ipv4_front.sv]
// Front end: accepts characters and classifies them into queue requests.
module ipv4_front (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          character,
	input  logic                has_character,
	input  logic                last,
	input  logic                q_full,
	output logic                q_push,
	output ipv4_pkg::char_req_t q_data
);

	logic [7:0] offset;

	assign offset   = character - ipv4_pkg::CHAR_ZERO;
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.last  = last;
		q_data.digit = offset[3:0];
		if (!has_character) begin
			q_data.kind = ipv4_pkg::KIND_NONE;
		end else if (character == ipv4_pkg::CHAR_DOT) begin
			q_data.kind = ipv4_pkg::KIND_DOT;
		end else if (character >= ipv4_pkg::CHAR_ZERO && character <= ipv4_pkg::CHAR_NINE) begin
			q_data.kind = ipv4_pkg::KIND_DIGIT;
		end else begin
			q_data.kind = ipv4_pkg::KIND_OTHER;
		end
	end

endmodule

[design/ipv4_queue.sv]
// Short request queue between the front end and the back end.
module ipv4_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ipv4_pkg::char_req_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output ipv4_pkg::char_req_t pop_data
);

	ipv4_pkg::char_req_t                 mem_q [ipv4_pkg::Q_DEPTH];
	logic [ipv4_pkg::Q_PTR_W-1:0]        wr_ptr_q;
	logic [ipv4_pkg::Q_PTR_W-1:0]        rd_ptr_q;
	logic [ipv4_pkg::Q_CNT_W-1:0]        count_q;

	assign full      = (count_q == ipv4_pkg::Q_CNT_W'(ipv4_pkg::Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/ipv4_back.sv]
// Back end: per-part parse state, final judgment and the result register.
module ipv4_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  ipv4_pkg::char_req_t q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         address,
	output logic [2:0]          status
);

	logic [2:0]        dot_count_q;
	logic [2:0]        digit_count_q;
	logic [9:0]        octet_value_q;
	logic              bad_char_q;
	ipv4_pkg::status_t first_err_q;
	logic [31:0]       addr_so_far_q;
	logic              out_valid_q;
	logic [31:0]       address_q;
	ipv4_pkg::status_t status_q;

	logic [2:0]        dot_a;
	logic [2:0]        dc_a;
	logic [9:0]        ov_a;
	logic              bad_a;
	ipv4_pkg::status_t fe_a;
	logic [31:0]       addr_a;
	ipv4_pkg::status_t err_dot;
	ipv4_pkg::status_t err_end;
	ipv4_pkg::status_t final_status;
	logic [31:0]       final_addr;
	logic              out_free;

	function automatic ipv4_pkg::status_t part_err(input logic [2:0] dc, input logic bad,
			input logic [9:0] ov);
		ipv4_pkg::status_t e;
		if (dc == 3'd0) begin
			e = ipv4_pkg::ST_EMPTY;
		end else if (dc > ipv4_pkg::MAX_DIGITS) begin
			e = ipv4_pkg::ST_LONG;
		end else if (bad) begin
			e = ipv4_pkg::ST_BADCHAR;
		end else if (ov > ipv4_pkg::MAX_OCTET) begin
			e = ipv4_pkg::ST_RANGE;
		end else begin
			e = ipv4_pkg::ST_OK;
		end
		return e;
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = q_not_empty && (!q_data.last || out_free);
	assign out_valid = out_valid_q;
	assign address   = address_q;
	assign status    = status_q;
	assign err_dot   = part_err(digit_count_q, bad_char_q, octet_value_q);

	always_comb begin
		dot_a  = dot_count_q;
		dc_a   = digit_count_q;
		ov_a   = octet_value_q;
		bad_a  = bad_char_q;
		fe_a   = first_err_q;
		addr_a = addr_so_far_q;
		case (q_data.kind)
			ipv4_pkg::KIND_DOT: begin
				if (first_err_q == ipv4_pkg::ST_OK) begin
					fe_a = err_dot;
					if (err_dot == ipv4_pkg::ST_OK) begin
						addr_a = {addr_so_far_q[23:0], octet_value_q[7:0]};
					end
				end
				dc_a  = '0;
				ov_a  = '0;
				bad_a = 1'b0;
				if (dot_count_q < ipv4_pkg::SAT_COUNT) begin
					dot_a = dot_count_q + 3'd1;
				end
			end
			ipv4_pkg::KIND_DIGIT: begin
				if (digit_count_q < ipv4_pkg::MAX_DIGITS) begin
					ov_a = {octet_value_q[6:0], 3'b000} + {octet_value_q[8:0], 1'b0}
						+ {6'd0, q_data.digit};
				end
				if (digit_count_q < ipv4_pkg::SAT_COUNT) begin
					dc_a = digit_count_q + 3'd1;
				end
			end
			ipv4_pkg::KIND_OTHER: begin
				bad_a = 1'b1;
				if (digit_count_q < ipv4_pkg::SAT_COUNT) begin
					dc_a = digit_count_q + 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		err_end = part_err(dc_a, bad_a, ov_a);
		if (dot_a != ipv4_pkg::DOTS_OK) begin
			final_status = ipv4_pkg::ST_PARTS;
		end else if (fe_a != ipv4_pkg::ST_OK) begin
			final_status = fe_a;
		end else begin
			final_status = err_end;
		end
		if (final_status == ipv4_pkg::ST_OK) begin
			final_addr = {addr_a[23:0], ov_a[7:0]};
		end else begin
			final_addr = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_count_q   <= '0;
			digit_count_q <= '0;
			octet_value_q <= '0;
			bad_char_q    <= 1'b0;
			first_err_q   <= ipv4_pkg::ST_OK;
			addr_so_far_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (q_pop && q_data.last) begin
				dot_count_q   <= '0;
				digit_count_q <= '0;
				octet_value_q <= '0;
				bad_char_q    <= 1'b0;
				first_err_q   <= ipv4_pkg::ST_OK;
				addr_so_far_q <= '0;
			end else if (q_pop) begin
				dot_count_q   <= dot_a;
				digit_count_q <= dc_a;
				octet_value_q <= ov_a;
				bad_char_q    <= bad_a;
				first_err_q   <= fe_a;
				addr_so_far_q <= addr_a;
			end
			if (q_pop && q_data.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			address_q <= final_addr;
			status_q  <= final_status;
		end
	end

endmodule

[dv/tb_ipv4_dotted_quad_parser.sv]
// Testbench for the IPv4 dotted-quad parser, checked against a built-in parse predictor.
`timescale 1ns / 100ps

module tb_ipv4_dotted_quad_parser;
	import ipv4_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 10;

	typedef struct {
		logic [31:0] address;
		status_t     status;
	} parse_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  character;
	logic        has_character;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] address;
	logic [2:0]  status;

	parse_result_t expected_results[$];
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int items_sent    = 0;
	int error_count   = 0;

	logic [2:0]  dots_seen;
	logic [2:0]  part_len;
	logic [9:0]  part_value;
	logic        part_has_bad;
	status_t     first_part_err;
	logic [31:0] packed_addr;

	ipv4_dotted_quad_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.character(character),
		.has_character(has_character),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.address(address),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("ERROR at %0t ns: %s", $time, what);
	endtask

	function automatic void clear_parse_state();
		dots_seen = '0;
		part_len = '0;
		part_value = '0;
		part_has_bad = 1'b0;
		first_part_err = ST_OK;
		packed_addr = '0;
	endfunction

	function automatic void close_current_part();
		status_t err;
		err = ST_OK;
		if (part_len == 3'd0)
			err = ST_EMPTY;
		else if (part_len > MAX_DIGITS)
			err = ST_LONG;
		else if (part_has_bad)
			err = ST_BADCHAR;
		else if (part_value > MAX_OCTET)
			err = ST_RANGE;
		if (first_part_err == ST_OK) begin
			first_part_err = err;
			if (err == ST_OK)
				packed_addr = {packed_addr[23:0], part_value[7:0]};
		end
		part_len = '0;
		part_value = '0;
		part_has_bad = 1'b0;
	endfunction

	function automatic void predict_parse(input logic [7:0] ch, input logic has,
			input logic lst);
		parse_result_t res;
		if (has) begin
			if (ch == CHAR_DOT) begin
				close_current_part();
				if (dots_seen < SAT_COUNT)
					dots_seen++;
			end else begin
				if (ch < CHAR_ZERO || ch > CHAR_NINE)
					part_has_bad = 1'b1;
				else if (part_len < MAX_DIGITS)
					part_value = 10'(part_value * 10 + (ch - CHAR_ZERO));
				if (part_len < SAT_COUNT)
					part_len++;
			end
		end
		if (lst) begin
			if (dots_seen != DOTS_OK) begin
				res.status = ST_PARTS;
			end else begin
				close_current_part();
				res.status = first_part_err;
			end
			res.address = (res.status == ST_OK) ? packed_addr : 32'd0;
			expected_results.push_back(res);
			clear_parse_state();
		end
	endfunction

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_char(input logic [7:0] ch, input logic has, input logic lst);
		int gap;
		logic taken;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		character <= ch;
		has_character <= has;
		last <= lst;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predict_parse(ch, has, lst);
		if (has || lst)
			items_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] txt[$], input logic end_item);
		for (int i = 0; i < txt.size(); i++) begin
			if ($urandom_range(99) < 3)
				send_char(8'($urandom_range(255)), 1'b0, 1'b0);
			send_char(txt[i], 1'b1, !end_item && i == txt.size() - 1);
		end
		if (end_item || txt.size() == 0)
			send_char(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic send_text(input string s, input logic end_item);
		logic [7:0] txt[$];
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
		send_bytes(txt, end_item);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	function automatic logic [7:0] random_nondigit();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CHAR_DOT || (b >= CHAR_ZERO && b <= CHAR_NINE));
		return b;
	endfunction

	function automatic void add_number(ref logic [7:0] txt[$], input int value,
			input int width);
		logic [7:0] digs[$];
		int v;
		v = value;
		do begin
			digs.push_front(CHAR_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v > 0);
		while (digs.size() < width)
			digs.push_front(CHAR_ZERO);
		foreach (digs[i])
			txt.push_back(digs[i]);
	endfunction

	function automatic void add_part(ref logic [7:0] txt[$]);
		int kind;
		int sel;
		int n;
		int pos;
		int base;
		kind = $urandom_range(99);
		if (kind < 70) begin
			sel = $urandom_range(9);
			add_number(txt, (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(255),
				($urandom_range(3) == 0) ? $urandom_range(1, 3) : 1);
		end else if (kind < 75) begin
		end else if (kind < 82) begin
			n = $urandom_range(4, 6);
			repeat (n)
				txt.push_back(CHAR_ZERO + 8'($urandom_range(9)));
			if ($urandom_range(2) == 0)
				txt[txt.size() - 1 - $urandom_range(n - 1)] = random_nondigit();
		end else if (kind < 90) begin
			n = $urandom_range(1, 3);
			base = txt.size();
			repeat (n)
				txt.push_back(CHAR_ZERO + 8'($urandom_range(9)));
			pos = $urandom_range(n - 1);
			txt[base + pos] = random_nondigit();
		end else begin
			add_number(txt, $urandom_range(256, 999), 3);
		end
	endfunction

	task automatic send_random_string();
		logic [7:0] txt[$];
		int kind;
		int parts;
		int sel;
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 16)) begin
				sel = $urandom_range(9);
				if (sel < 2)
					txt.push_back(CHAR_DOT);
				else if (sel < 5)
					txt.push_back(CHAR_ZERO + 8'($urandom_range(9)));
				else
					txt.push_back(8'($urandom_range(255)));
			end
		end else begin
			parts = (kind < 85) ? 4 : $urandom_range(0, 7);
			for (int p = 0; p < parts; p++) begin
				if (p > 0)
					txt.push_back(CHAR_DOT);
				add_part(txt);
			end
		end
		send_bytes(txt, $urandom_range(4) == 0);
	endtask

	task automatic test_directed_strings();
		send_char(8'h41, 1'b0, 1'b0);
		send_text("", 1'b0);
		send_text("9.255.0.1", 1'b1);
		send_text("...", 1'b0);
		send_text("1.2.3.256", 1'b0);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_in_pct,
			input int count);
		int target;
		send_idle_pct = idle_pct;
		stall_pct = stall_in_pct;
		target = items_sent + count;
		while (items_sent < target)
			send_random_string();
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 0;
		stall_pct = 70;
		repeat (6)
			send_random_string();
		wait_drained();
		repeat (6)
			send_random_string();
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		parse_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result address=%h status=%0d",
						address, status));
				end else begin
					want = expected_results.pop_front();
					if (address !== want.address)
						report_mismatch($sformatf("address %h, expected %h",
							address, want.address));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL ipv4_dotted_quad_parser");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		character <= '0;
		has_character <= 1'b0;
		last <= 1'b0;
		clear_parse_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_strings();
		test_random_phase(0, 0, 210);
		test_random_phase(70, 0, 210);
		test_drain_pause();
		test_random_phase(0, 70, 210);
		test_random_phase(21, 21, 210);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS ipv4_dotted_quad_parser");
		else
			$display("FAIL ipv4_dotted_quad_parser");
		$finish;
	end

endmodule
